### sv/buk_pkg.sv
// Package with the shared types, widths and codes of the bounded unique key set.
`timescale 1ns / 1ps

package buk_pkg;

    localparam int KEY_W      = 31;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int CAPACITY   = 16;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic capture;
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

### sv/buk_cmd_if.sv
// Command channel interface carrying an operation code and a key.
`timescale 1ns / 1ps

interface buk_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [buk_pkg::OP_W-1:0]      operation;
    logic [buk_pkg::KEY_W-1:0]     key;

    modport source (output valid, output operation, output key, input ready);
    modport sink (input valid, input operation, input key, output ready);
endinterface

### sv/buk_rsp_if.sv
// Response channel interface carrying status, found flag and count.
`timescale 1ns / 1ps

interface buk_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [buk_pkg::STATUS_W-1:0]   status;
    logic                           found;
    logic [buk_pkg::COUNT_W-1:0]    count;

    modport source (output valid, output status, output found, output count, input ready);
    modport sink (input valid, input status, input found, input count, output ready);
endinterface

### sv/buk_cell.sv
// One storage cell of the key row: holds a key, compares it, loads a new key or takes its neighbor's key.
`timescale 1ns / 1ps

module buk_cell (
    input  logic               i_clk,
    input  buk_pkg::t_cell_ctl i_ctl,
    input  logic               i_valid,
    input  buk_pkg::t_key      i_key,
    input  buk_pkg::t_key      i_next_key,
    output buk_pkg::t_key      o_key,
    output logic               o_match
);

    buk_pkg::t_key r_key;
    logic          r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_match <= i_valid && (r_key == i_key);
        end
        if (i_ctl.load) begin
            r_key <= i_key;
        end else if (i_ctl.shift) begin
            r_key <= i_next_key;
        end
    end

    assign o_key   = r_key;
    assign o_match = r_match;

endmodule

### sv/bounded_unique_key_set.sv
// Top level of the bounded unique key set built as a row of key cells.
// Each command is handled as a compare in all cells when it is accepted, then an update of the cells and
// the registered response in the execute state; no new command is taken until the update is done.
// A response waiting in the output register holds the update, so no further command is taken meanwhile.
// Reset clears the key count and the handshake state; cell contents stay undefined.
`timescale 1ns / 1ps

module bounded_unique_key_set #(
    parameter int CAPACITY = buk_pkg::CAPACITY
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    buk_cmd_if.sink   i_cmd,
    buk_rsp_if.source o_rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]             r_count, n_count;
    logic [buk_pkg::OP_W-1:0]     r_op;
    buk_pkg::t_key                r_key;

    logic                         r_out_valid;
    logic [buk_pkg::STATUS_W-1:0] r_status;
    logic                         r_found;
    logic [buk_pkg::COUNT_W-1:0]  r_count_out;

    buk_pkg::t_key                w_cell_key [CAPACITY];
    logic [CAPACITY-1:0]          w_match;
    buk_pkg::t_cell_ctl           w_ctl      [CAPACITY];

    logic                         w_accept;
    logic                         w_out_free;
    logic                         w_fire;
    logic                         w_present;
    logic                         w_full;
    logic                         w_do_ins;
    logic                         w_do_rem;
    logic [IDX_W-1:0]             w_pos;
    logic [buk_pkg::STATUS_W-1:0] w_status;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_fire      = (r_state == S_EXEC) && w_out_free;

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            buk_pkg::t_key w_next;

            if (g == CAPACITY - 1) begin : g_last
                assign w_next = w_cell_key[g];
            end else begin : g_mid
                assign w_next = w_cell_key[g+1];
            end

            assign w_ctl[g].capture = w_accept;
            assign w_ctl[g].load    = w_fire && w_do_ins && (r_count == CNT_W'(g));
            assign w_ctl[g].shift   = w_fire && w_do_rem && (IDX_W'(g) >= w_pos);

            buk_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[g]),
                .i_valid    (CNT_W'(g) < r_count),
                .i_key      (w_accept ? i_cmd.key : r_key),
                .i_next_key (w_next),
                .o_key      (w_cell_key[g]),
                .o_match    (w_match[g])
            );
        end
    endgenerate

    // Keys are unique, so at most one cell matches and an OR of the indexes encodes it.
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_match[i]) begin
                w_pos = w_pos | IDX_W'(i);
            end
        end
    end

    assign w_present = |w_match;
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_do_ins  = (r_op == buk_pkg::OP_INSERT) && !w_full && !w_present;
    assign w_do_rem  = (r_op == buk_pkg::OP_REMOVE) && w_present;

    always_comb begin
        n_count = r_count;
        if (w_do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        case (r_op)
            buk_pkg::OP_INSERT: begin
                if (w_full) begin
                    w_status = buk_pkg::ST_FULL;
                end else if (w_present) begin
                    w_status = buk_pkg::ST_DUP;
                end else begin
                    w_status = buk_pkg::ST_DONE;
                end
            end
            default: begin
                w_status = w_present ? buk_pkg::ST_DONE : buk_pkg::ST_MISSING;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_cmd.operation;
            r_key <= i_cmd.key;
        end
        if (w_fire) begin
            r_status    <= w_status;
            r_found     <= w_present;
            r_count_out <= buk_pkg::COUNT_W'(n_count);
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_status;
    assign o_rsp.found  = r_found;
    assign o_rsp.count  = r_count_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("Key count exceeds the capacity.");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(w_match))
        else $error("More than one cell matched the key.");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_do_ins) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("Insert did not increment the count.");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_do_rem) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("Remove did not decrement the count.");

    a_dup_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == buk_pkg::ST_DUP)) |-> r_found)
        else $error("Duplicate status without a found key.");

endmodule
